// File: rtl/hsv2rgb_pkg.sv
// Package with the shared types and constants of the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    // Channel format: unsigned fixed point, FB fraction bits, one guard bit for 1.0.
    localparam int FB   = 16;
    localparam int CH_W = FB + 1;
    localparam logic [CH_W-1:0] CH_ONE = CH_W'(1) << FB;

    // Hue in 1/64 degree: one sector is 60 degrees, a full turn is 360 degrees.
    localparam int HUE_W      = 15;
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;
    localparam int REM_W      = 12;
    localparam int SECTOR_W   = 3;

    // Reciprocal of the sector width, exact for every remainder shifted up by FB.
    localparam int              RECIP_SHIFT = 40;
    localparam int              RECIP_W     = 29;
    localparam longint unsigned RECIP_MUL   =
        ((64'd1 << RECIP_SHIFT) + HUE_SECTOR - 1) / HUE_SECTOR;

    typedef enum logic [SECTOR_W-1:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        sector_t         sector;
        logic [FB-1:0]   f;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] p;
    } frac_t;

    typedef struct packed {
        sector_t         sector;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
    } term_t;

endpackage

`default_nettype wire

// File: rtl/hsv2rgb_sector.sv
// Front two pipeline stages: sector split, sector fraction and the p term.
`default_nettype none

module hsv2rgb_sector (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hsv2rgb_pkg::hsv_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hsv2rgb_pkg::frac_t   out_data
);

    localparam int CW  = hsv2rgb_pkg::CH_W;
    localparam int FBW = hsv2rgb_pkg::FB;
    localparam int HW  = hsv2rgb_pkg::HUE_W;
    localparam int RW  = hsv2rgb_pkg::REM_W;
    localparam int MW  = hsv2rgb_pkg::RECIP_W;

    function automatic logic [CW-1:0] clamp_unit(input logic [CW-1:0] x);
        return (x > hsv2rgb_pkg::CH_ONE) ? hsv2rgb_pkg::CH_ONE : x;
    endfunction

    // Stage A: clamped operands, sector and remainder within the sector.
    logic                   a_valid_reg;
    hsv2rgb_pkg::sector_t   a_sector_reg;
    logic [RW-1:0]          a_rem_reg;
    logic [CW-1:0]          a_sat_reg;
    logic [CW-1:0]          a_val_reg;

    // Stage B: fraction and p.
    logic                   b_valid_reg;
    hsv2rgb_pkg::frac_t     b_data_reg;
    hsv2rgb_pkg::frac_t     b_next;

    logic                   a_ready;
    logic                   b_ready;
    logic [HW-1:0]          hue_eff;
    hsv2rgb_pkg::sector_t   sector_next;
    logic [HW-1:0]          base_next;
    logic [RW+FBW-1:0]      f_num;
    logic [RW+FBW+MW-1:0]   f_prod;
    logic [2*CW-1:0]        p_prod;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // A hue of a full turn or more counts as zero; the sector comes from five
    // parallel compares against the sector boundaries.
    always_comb
    begin
        hue_eff     = (in_data.hue >= HW'(hsv2rgb_pkg::HUE_FULL)) ? '0 : in_data.hue;
        sector_next = hsv2rgb_pkg::SEC_R_Y;
        base_next   = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (hue_eff >= HW'(k * hsv2rgb_pkg::HUE_SECTOR))
            begin
                sector_next = hsv2rgb_pkg::sector_t'(hsv2rgb_pkg::SECTOR_W'(k));
                base_next   = HW'(k * hsv2rgb_pkg::HUE_SECTOR);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_sector_reg <= sector_next;
            a_rem_reg    <= RW'(hue_eff - base_next);
            a_sat_reg    <= clamp_unit(in_data.saturation);
            a_val_reg    <= clamp_unit(in_data.brightness);
        end
    end

    // f = (rem << FB) / 3840 through a multiply by the rounded-up reciprocal.
    always_comb
    begin
        f_num         = {a_rem_reg, FBW'(0)};
        f_prod        = f_num * MW'(hsv2rgb_pkg::RECIP_MUL);
        p_prod        = a_val_reg * (hsv2rgb_pkg::CH_ONE - a_sat_reg);
        b_next.sector = a_sector_reg;
        b_next.f      = f_prod[hsv2rgb_pkg::RECIP_SHIFT +: FBW];
        b_next.sat    = a_sat_reg;
        b_next.val    = a_val_reg;
        b_next.p      = p_prod[FBW +: CW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsv2rgb_terms.sv
// Middle two pipeline stages: the scaled saturation products, then q and t.
`default_nettype none

module hsv2rgb_terms (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hsv2rgb_pkg::frac_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hsv2rgb_pkg::term_t   out_data
);

    localparam int CW  = hsv2rgb_pkg::CH_W;
    localparam int FBW = hsv2rgb_pkg::FB;

    // Stage C: s*f and s*(1-f), truncated.
    logic                   c_valid_reg;
    hsv2rgb_pkg::sector_t   c_sector_reg;
    logic [CW-1:0]          c_val_reg;
    logic [CW-1:0]          c_p_reg;
    logic [CW-1:0]          c_sf_reg;
    logic [CW-1:0]          c_sfc_reg;

    // Stage D: q and t.
    logic                   d_valid_reg;
    hsv2rgb_pkg::term_t     d_data_reg;
    hsv2rgb_pkg::term_t     d_next;

    logic                   c_ready;
    logic                   d_ready;
    logic [CW-1:0]          f_comp;
    logic [CW+FBW-1:0]      sf_prod;
    logic [2*CW-1:0]        sfc_prod;
    logic [2*CW-1:0]        q_prod;
    logic [2*CW-1:0]        t_prod;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb
    begin
        f_comp   = hsv2rgb_pkg::CH_ONE - {1'b0, in_data.f};
        sf_prod  = in_data.sat * in_data.f;
        sfc_prod = in_data.sat * f_comp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_sector_reg <= in_data.sector;
            c_val_reg    <= in_data.val;
            c_p_reg      <= in_data.p;
            c_sf_reg     <= sf_prod[FBW +: CW];
            c_sfc_reg    <= sfc_prod[FBW +: CW];
        end
    end

    always_comb
    begin
        q_prod        = c_val_reg * (hsv2rgb_pkg::CH_ONE - c_sf_reg);
        t_prod        = c_val_reg * (hsv2rgb_pkg::CH_ONE - c_sfc_reg);
        d_next.sector = c_sector_reg;
        d_next.val    = c_val_reg;
        d_next.p      = c_p_reg;
        d_next.q      = q_prod[FBW +: CW];
        d_next.t      = t_prod[FBW +: CW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_data_reg <= d_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsv2rgb_route.sv
// Output stage: routes v, p, q and t to the color channels by sector.
`default_nettype none

module hsv2rgb_route (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hsv2rgb_pkg::term_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hsv2rgb_pkg::rgb_t    out_data
);

    logic                 out_valid_reg;
    hsv2rgb_pkg::rgb_t    out_data_reg;
    hsv2rgb_pkg::rgb_t    rgb_next;

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (in_data.sector)
            hsv2rgb_pkg::SEC_R_Y: rgb_next = '{in_data.val, in_data.t, in_data.p};
            hsv2rgb_pkg::SEC_Y_G: rgb_next = '{in_data.q, in_data.val, in_data.p};
            hsv2rgb_pkg::SEC_G_C: rgb_next = '{in_data.p, in_data.val, in_data.t};
            hsv2rgb_pkg::SEC_C_B: rgb_next = '{in_data.p, in_data.q, in_data.val};
            hsv2rgb_pkg::SEC_B_M: rgb_next = '{in_data.t, in_data.p, in_data.val};
            hsv2rgb_pkg::SEC_M_R: rgb_next = '{in_data.val, in_data.p, in_data.q};
            default:              rgb_next = '{in_data.val, in_data.p, in_data.q};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_data_reg <= rgb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_core.sv
// Top level of the pipelined HSV to RGB pixel converter.
//
// Converts one HSV pixel per clock, while the output is not stalled, into RGB
// with five register stages and no stored state between pixels: each accepted
// transaction yields exactly one result transaction. Throughput is one pixel
// per cycle; it is set by the pipeline itself, since each stage holds one
// pixel and every stage advances whenever the stage after it is empty or
// moving. The stages are: hue sector split and operand clamp, sector
// fraction by reciprocal multiply together with p = v(1-s), the products
// s*f and s*(1-f), the products q and t against value, and finally the
// routing of v, p, q and t to red, green and blue in the output register.
// Hue is in 1/64 degree and a hue of a full turn or more is read as zero;
// saturation, value and the channels are unsigned with 16 fraction bits, and
// a saturation or value above 1.0 is clamped to 1.0. Zero saturation gives a
// grey pixel with every channel equal to value. Each valid bit travels with
// its pixel and ready ripples back stage by stage, so a stalled output fills
// the bubbles in front of it before the input side sees ready fall.
`default_nettype none

module hsv_to_rgb_converter_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 hsv_valid,
    output logic                 hsv_ready,
    input  hsv2rgb_pkg::hsv_t    hsv,
    output logic                 rgb_valid,
    input  logic                 rgb_ready,
    output hsv2rgb_pkg::rgb_t    rgb
);

    logic                 frac_valid;
    logic                 frac_ready;
    hsv2rgb_pkg::frac_t   frac_data;
    logic                 term_valid;
    logic                 term_ready;
    hsv2rgb_pkg::term_t   term_data;

    // Sector, fraction and p.
    hsv2rgb_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_valid),
        .in_ready  (hsv_ready),
        .in_data   (hsv),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .out_data  (frac_data)
    );

    // Saturation products, then q and t.
    hsv2rgb_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .in_data   (frac_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    // Channel routing into the output register.
    hsv2rgb_route u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .out_data  (rgb)
    );

endmodule

`default_nettype wire

// File: rtl/hsv2rgb_checker.sv
// Port-level assertion checker for the HSV to RGB converter, with its bind.
`default_nettype none

module hsv2rgb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 hsv_valid,
    input logic                 hsv_ready,
    input hsv2rgb_pkg::hsv_t    hsv,
    input logic                 rgb_valid,
    input logic                 rgb_ready,
    input hsv2rgb_pkg::rgb_t    rgb
);

    logic in_acc;

    assign in_acc = hsv_valid && hsv_ready;

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
        else $error("result changed or dropped while stalled");

    // Every channel is a fraction no larger than 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> rgb.red <= hsv2rgb_pkg::CH_ONE
                   && rgb.green <= hsv2rgb_pkg::CH_ONE
                   && rgb.blue <= hsv2rgb_pkg::CH_ONE)
        else $error("channel above 1.0");

    // The input side only backs up when the whole pipeline is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_ready |-> rgb_valid && !rgb_ready)
        else $error("input not ready while output is free");

    // With no new pixels and a free output throughout, the pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3)
        && !$past(in_acc, 4) && !$past(in_acc, 5) && !$past(in_acc, 6)
        && $past(rgb_ready, 1) && $past(rgb_ready, 2) && $past(rgb_ready, 3)
        && $past(rgb_ready, 4) && $past(rgb_ready, 5) && $past(rgb_ready, 6)
        |-> !rgb_valid)
        else $error("result appeared without a matching transaction");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
);

`default_nettype wire

// File: sim/tb_hsv_to_rgb_converter_core.sv
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_core;

    localparam int CLK_PERIOD = 10;

    localparam int HUE_W      = hsv2rgb_pkg::HUE_W;
    localparam int CH_W       = hsv2rgb_pkg::CH_W;
    localparam int FB         = hsv2rgb_pkg::FB;
    localparam int HUE_SECTOR = hsv2rgb_pkg::HUE_SECTOR;
    localparam int HUE_FULL   = hsv2rgb_pkg::HUE_FULL;
    localparam int SECTOR_W   = hsv2rgb_pkg::SECTOR_W;
    localparam logic [CH_W-1:0] CH_ONE = hsv2rgb_pkg::CH_ONE;

    // Cycles to wait after the last expected pixel before the final verdict.
    // The pipeline has five register stages, so this is comfortably past it.
    localparam int DRAIN_CYCLES = 20;

    // Length of the deliberate output stall in the last phase. It is far
    // longer than the pipeline depth, so the block must fill and drop hsv_ready.
    localparam int HOLD_OFF_CYCLES = 150;

    localparam logic [CH_W-1:0] CH_MAX = '1;
    localparam logic [CH_W-1:0] CH_ZERO = '0;

    // One row of the directed table. When has_rgb is set, the expected
    // pixel is typed in by hand; otherwise it comes from the predictor.
    typedef struct packed {
        hsv2rgb_pkg::hsv_t px;
        logic              has_rgb;
        hsv2rgb_pkg::rgb_t rgb;
    } pixel_case_t;

    localparam int NUM_DIRECTED = 22;

    localparam pixel_case_t DIRECTED_CASES [NUM_DIRECTED] = '{
        // Black and white greys: zero saturation copies value to all channels.
        '{'{HUE_W'(0), CH_ZERO, CH_ZERO}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ZERO}},
        '{'{HUE_W'(0), CH_ZERO, CH_ONE}, 1'b1, '{CH_ONE, CH_ONE, CH_ONE}},
        // Grey with an out-of-range value, which is clamped to 1.0.
        '{'{HUE_W'(32767), CH_ZERO, CH_MAX}, 1'b1, '{CH_ONE, CH_ONE, CH_ONE}},
        // The six primary and secondary colors at the start of each sector.
        '{'{HUE_W'(0), CH_ONE, CH_ONE}, 1'b1, '{CH_ONE, CH_ZERO, CH_ZERO}},
        '{'{HUE_W'(1 * HUE_SECTOR), CH_ONE, CH_ONE}, 1'b1, '{CH_ONE, CH_ONE, CH_ZERO}},
        '{'{HUE_W'(2 * HUE_SECTOR), CH_ONE, CH_ONE}, 1'b1, '{CH_ZERO, CH_ONE, CH_ZERO}},
        '{'{HUE_W'(3 * HUE_SECTOR), CH_ONE, CH_ONE}, 1'b1, '{CH_ZERO, CH_ONE, CH_ONE}},
        '{'{HUE_W'(4 * HUE_SECTOR), CH_ONE, CH_ONE}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ONE}},
        '{'{HUE_W'(5 * HUE_SECTOR), CH_ONE, CH_ONE}, 1'b1, '{CH_ONE, CH_ZERO, CH_ONE}},
        // A full turn and the largest hue code both wrap to pure red.
        '{'{HUE_W'(HUE_FULL), CH_ONE, CH_ONE}, 1'b1, '{CH_ONE, CH_ZERO, CH_ZERO}},
        '{'{HUE_W'(32767), CH_MAX, CH_ONE}, 1'b1, '{CH_ONE, CH_ZERO, CH_ZERO}},
        // Zero value is black whatever the saturation.
        '{'{HUE_W'(0), CH_ONE, CH_ZERO}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ZERO}},
        // The rest go through the predictor: sector edges, mid-sector
        // fractions, tiny and clamped operands.
        '{'{HUE_W'(HUE_FULL - 1), CH_ONE, CH_ONE}, 1'b0, '0},
        '{'{HUE_W'(HUE_SECTOR - 1), CH_ONE, CH_ONE}, 1'b0, '0},
        '{'{HUE_W'(1), CH_W'(65535), CH_MAX}, 1'b0, '0},
        '{'{HUE_W'(1920), CH_W'(32768), CH_W'(40000)}, 1'b0, '0},
        '{'{HUE_W'(5000), CH_W'(1), CH_ONE}, 1'b0, '0},
        '{'{HUE_W'(9000), CH_MAX, CH_MAX}, 1'b0, '0},
        '{'{HUE_W'(13000), CH_W'(12345), CH_W'(54321)}, 1'b0, '0},
        '{'{HUE_W'(16384), CH_W'(100), CH_W'(17'h10001)}, 1'b0, '0},
        '{'{HUE_W'(17000), CH_ONE, CH_W'(1)}, 1'b0, '0},
        '{'{HUE_W'(21000), CH_W'(60000), CH_W'(65535)}, 1'b0, '0}
    };

    // Idle percentages per phase: the sender idles lightly while the
    // receiver stalls heavily, then the reverse, then both run flat out.
    localparam int NUM_PHASES = 3;
    localparam int SENDER_IDLE [NUM_PHASES] = '{33, 67, 0};
    localparam int RECEIVER_IDLE [NUM_PHASES] = '{67, 33, 0};
    localparam int RANDOM_PER_PHASE [NUM_PHASES] = '{333, 333, 334};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hsv_valid = 1'b0;
    logic hsv_ready;
    hsv2rgb_pkg::hsv_t hsv = '0;
    logic rgb_valid;
    logic rgb_ready = 1'b0;
    hsv2rgb_pkg::rgb_t rgb;

    // Pixels the block owes us, oldest first.
    hsv2rgb_pkg::rgb_t rgb_expected [$];
    int mismatches = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    // The main process raises hold_off_req; the receiver process owns the
    // stall countdown so that it is counted in cycles on its own side.
    logic hold_off_req = 1'b0;
    bit hold_off_taken = 1'b0;
    int hold_left = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    hsv_to_rgb_converter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

    // Fixed-point HSV to RGB conversion with truncated products. Saturation
    // and value are clamped to 1.0, a hue of a full turn or more reads as
    // zero, and the sector picks how v, p, q and t land on the channels.
    function automatic hsv2rgb_pkg::rgb_t convert_hsv(input hsv2rgb_pkg::hsv_t px);
        longint unsigned one;
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned f;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        hsv2rgb_pkg::sector_t sec;
        hsv2rgb_pkg::rgb_t c;

        one = longint'(CH_ONE);
        h = longint'(px.hue);
        s = (px.saturation > CH_ONE) ? one : longint'(px.saturation);
        v = (px.brightness > CH_ONE) ? one : longint'(px.brightness);

        if (s == 0)
        begin
            c.red = CH_W'(v);
            c.green = CH_W'(v);
            c.blue = CH_W'(v);
        end
        else
        begin
            if (h >= HUE_FULL)
            begin
                h = 0;
            end
            sec = hsv2rgb_pkg::sector_t'(SECTOR_W'(h / HUE_SECTOR));
            f = ((h % HUE_SECTOR) << FB) / HUE_SECTOR;
            p = (v * (one - s)) >> FB;
            q = (v * (one - ((s * f) >> FB))) >> FB;
            t = (v * (one - ((s * (one - f)) >> FB))) >> FB;
            case (sec)
                hsv2rgb_pkg::SEC_R_Y: c = '{CH_W'(v), CH_W'(t), CH_W'(p)};
                hsv2rgb_pkg::SEC_Y_G: c = '{CH_W'(q), CH_W'(v), CH_W'(p)};
                hsv2rgb_pkg::SEC_G_C: c = '{CH_W'(p), CH_W'(v), CH_W'(t)};
                hsv2rgb_pkg::SEC_C_B: c = '{CH_W'(p), CH_W'(q), CH_W'(v)};
                hsv2rgb_pkg::SEC_B_M: c = '{CH_W'(t), CH_W'(p), CH_W'(v)};
                default: c = '{CH_W'(v), CH_W'(p), CH_W'(q)};
            endcase
        end
        return c;
    endfunction

    // Channel operand with weight on zero, 1.0, values near the ends and
    // codes above 1.0, so that every bit of the field toggles.
    function automatic logic [CH_W-1:0] random_level();
        case ($urandom_range(9))
            0: return CH_ZERO;
            1: return CH_ONE;
            2: return CH_W'($urandom_range(131071));
            3: return CH_W'($urandom_range(15));
            4: return CH_ONE - CH_W'($urandom_range(15));
            default: return CH_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic hsv2rgb_pkg::hsv_t random_pixel();
        hsv2rgb_pkg::hsv_t px;

        case ($urandom_range(7))
            // Anywhere in the 15-bit code space, wrapped codes included.
            0: px.hue = HUE_W'($urandom_range(32767));
            // Right on or just below a sector boundary.
            1: px.hue = HUE_W'($urandom_range(6, 1) * HUE_SECTOR - $urandom_range(1));
            default: px.hue = HUE_W'($urandom_range(HUE_FULL - 1));
        endcase
        px.saturation = random_level();
        px.brightness = random_level();
        return px;
    endfunction

    // Offers one pixel and returns at the edge where the transaction is
    // accepted. Valid is only lowered when the sender chooses to idle, so a
    // back-to-back pixel keeps valid high with a single assignment per edge.
    task automatic send_pixel(input hsv2rgb_pkg::hsv_t px, input logic has_rgb,
                              input hsv2rgb_pkg::rgb_t rgb_typed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            hsv_valid <= 1'b0;
            @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv <= px;
        do
            @(posedge clk);
        while (!hsv_ready);
        rgb_expected.push_back(has_rgb ? rgb_typed : convert_hsv(px));
    endtask

    task automatic wait_for_drain();
        hsv_valid <= 1'b0;
        while (rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: checks every accepted result transaction against the oldest
    // expectation and then decides ready for the next edge. The long
    // hold-off takes priority over the random stalls.
    always @(posedge clk)
    begin
        hsv2rgb_pkg::rgb_t want;

        if (rst_n && rgb_valid && rgb_ready)
        begin
            if (rgb_expected.size() == 0)
            begin
                $error("Result transaction with no pixel pending: red %0d green %0d blue %0d",
                       rgb.red, rgb.green, rgb.blue);
                mismatches++;
            end
            else
            begin
                want = rgb_expected.pop_front();
                if (rgb.red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, rgb.red);
                    mismatches++;
                end
                if (rgb.green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, rgb.green);
                    mismatches++;
                end
                if (rgb.blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
                    mismatches++;
                end
            end
        end

        if (hold_left != 0)
        begin
            hold_left--;
            rgb_ready <= 1'b0;
        end
        else if (hold_off_req && !hold_off_taken)
        begin
            hold_off_taken = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            rgb_ready <= 1'b0;
        end
        else
        begin
            rgb_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Main sequence: reset, directed table, three random phases with
    // different idle mixes, then drain and report.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            sender_idle_pct = SENDER_IDLE[ph];
            receiver_idle_pct = RECEIVER_IDLE[ph];

            if (ph == 0)
            begin
                for (int i = 0; i < NUM_DIRECTED; i++)
                begin
                    send_pixel(DIRECTED_CASES[i].px, DIRECTED_CASES[i].has_rgb,
                               DIRECTED_CASES[i].rgb);
                end
            end

            for (int i = 0; i < RANDOM_PER_PHASE[ph]; i++)
            begin
                // In the flat-out phase, stall the output for a long stretch
                // while pixels keep coming, so the pipeline backs up to the input.
                if (ph == NUM_PHASES - 1 && i == 100)
                begin
                    hold_off_req <= 1'b1;
                end
                // Midway through the second phase the sender stops until the
                // pipeline has fully emptied, then resumes from idle.
                if (ph == 1 && i == 150)
                begin
                    wait_for_drain();
                end
                send_pixel(random_pixel(), 1'b0, '0);
            end

            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (rgb_expected.size() != 0)
        begin
            $error("%0d expected pixels never arrived", rgb_expected.size());
            mismatches++;
        end

        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: ends the run with a failure if the main sequence never finishes.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
